### sv/tdg_pkg.sv
// ----------------------------------------------------------------------------
// tdg_pkg: shared types and constants for the thermal clock governor
// Request, result, configuration and state records, plus the frequency,
// request, profile and display-command codes.
// ----------------------------------------------------------------------------
package tdg_pkg;

  localparam int TsW   = 32;
  localparam int TempW = 12;
  localparam int FreqW = 8;
  localparam int PerW  = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [FreqW-1:0] FREQ_HIGH = 8'd240;
  localparam logic [FreqW-1:0] FREQ_MID  = 8'd160;
  localparam logic [FreqW-1:0] FREQ_LOW  = 8'd80;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_ACTIVITY = 2'd1,
    REQ_PROFILE  = 2'd2,
    REQ_UNUSED   = 2'd3
  } req_type_t;

  localparam logic [1:0] PROF_AUTO     = 2'd0;
  localparam logic [1:0] PROF_PERF     = 2'd1;
  localparam logic [1:0] PROF_BALANCED = 2'd2;
  localparam logic [1:0] PROF_ECO      = 2'd3;

  localparam logic [1:0] CMD_NONE      = 2'd0;
  localparam logic [1:0] CMD_SLEEP_IN  = 2'd1;
  localparam logic [1:0] CMD_SLEEP_OUT = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_SLEEP_TIMEOUT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_THERMAL_PER   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TEMP_CRIT     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TEMP_THROT    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TEMP_RECOV    = 3'd4;

  localparam logic [TsW-1:0]          RST_SLEEP_TIMEOUT = 32'd0;
  localparam logic [PerW-1:0]         RST_THERMAL_PER   = 16'd1000;
  localparam logic signed [TempW-1:0] RST_TEMP_CRIT     = 12'sd1312;
  localparam logic signed [TempW-1:0] RST_TEMP_THROT    = 12'sd1200;
  localparam logic signed [TempW-1:0] RST_TEMP_RECOV    = 12'sd1088;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [TsW-1:0]          now_ms;
    logic signed [TempW-1:0] temperature;
    logic                    is_recording;
    logic                    is_streaming;
    logic                    is_high_load;
    logic [1:0]              new_profile;
  } in_req_t;

  typedef struct packed {
    logic [FreqW-1:0]        freq_mhz;
    logic [FreqW-1:0]        target_mhz;
    logic                    throttled;
    logic                    display_asleep;
    logic [1:0]              display_cmd;
    logic                    freq_changed;
    logic signed [TempW-1:0] temp_latched;
  } out_rsp_t;

  typedef struct packed {
    logic [TsW-1:0]          sleep_timeout_ms;
    logic [PerW-1:0]         thermal_period_ms;
    logic signed [TempW-1:0] temp_critical;
    logic signed [TempW-1:0] temp_throttle;
    logic signed [TempW-1:0] temp_recovery;
  } tdg_cfg_t;

  typedef struct packed {
    logic [FreqW-1:0]        cur_freq;
    logic [FreqW-1:0]        target_freq;
    logic [1:0]              profile_mode;
    logic                    throttle_flag;
    logic                    display_sleep_flag;
    logic [TsW-1:0]          last_check_ms;
    logic [TsW-1:0]          last_activity_ms;
    logic signed [TempW-1:0] latched_temp;
  } gov_state_t;

  // Target frequency selected by a profile; auto starts high.
  function automatic logic [FreqW-1:0] profile_target(input logic [1:0] prof);
    logic [FreqW-1:0] f;
    case (prof)
      PROF_PERF:     f = FREQ_HIGH;
      PROF_BALANCED: f = FREQ_MID;
      PROF_ECO:      f = FREQ_LOW;
      default:       f = FREQ_HIGH;
    endcase
    return f;
  endfunction

endpackage

### sv/tdg_cfg_regs.sv
// ----------------------------------------------------------------------------
// tdg_cfg_regs: governor configuration registers
// Sleep timeout, thermal period and the three temperature thresholds,
// written through the configuration channel.
// ----------------------------------------------------------------------------
module tdg_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [tdg_pkg::CfgIdxW-1:0]   wr_idx,
  input  logic [tdg_pkg::CfgDataW-1:0]  wr_data,
  output tdg_pkg::tdg_cfg_t             cfg
);
  import tdg_pkg::*;

  tdg_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sleep_timeout_ms  <= RST_SLEEP_TIMEOUT;
      cfg_r.thermal_period_ms <= RST_THERMAL_PER;
      cfg_r.temp_critical     <= RST_TEMP_CRIT;
      cfg_r.temp_throttle     <= RST_TEMP_THROT;
      cfg_r.temp_recovery     <= RST_TEMP_RECOV;
    end else if (wr_en) begin
      case (wr_idx)
        REG_SLEEP_TIMEOUT: cfg_r.sleep_timeout_ms  <= wr_data[TsW-1:0];
        REG_THERMAL_PER:   cfg_r.thermal_period_ms <= wr_data[PerW-1:0];
        REG_TEMP_CRIT:     cfg_r.temp_critical     <= $signed(wr_data[TempW-1:0]);
        REG_TEMP_THROT:    cfg_r.temp_throttle     <= $signed(wr_data[TempW-1:0]);
        REG_TEMP_RECOV:    cfg_r.temp_recovery     <= $signed(wr_data[TempW-1:0]);
        default: ;  // unmapped index: drop
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/tdg_step.sv
// ----------------------------------------------------------------------------
// tdg_step: governor next-state and result logic
// Evaluates one request against the current state and configuration:
// thermal check, auto retarget, idle sleep, activity wake, profile change.
// ----------------------------------------------------------------------------
module tdg_step (
  input  tdg_pkg::in_req_t    req,
  input  tdg_pkg::gov_state_t st,
  input  tdg_pkg::tdg_cfg_t   cfg,
  output tdg_pkg::gov_state_t st_nxt,
  output tdg_pkg::out_rsp_t   rsp
);
  import tdg_pkg::*;

  logic [TsW-1:0]   check_elapsed;
  logic [TsW-1:0]   idle_elapsed;
  logic             check_due;
  logic             idle_due;
  logic [FreqW-1:0] want_freq;
  logic             changed;
  logic [1:0]       cmd;

  assign check_elapsed = req.now_ms - st.last_check_ms;
  assign idle_elapsed  = req.now_ms - st.last_activity_ms;
  assign check_due     = check_elapsed >= {{(TsW-PerW){1'b0}}, cfg.thermal_period_ms};
  assign idle_due      = idle_elapsed >= cfg.sleep_timeout_ms;
  assign want_freq     = (req.is_recording || req.is_streaming || req.is_high_load)
                         ? FREQ_HIGH : FREQ_MID;

  always_comb begin
    st_nxt  = st;
    changed = 1'b0;
    cmd     = CMD_NONE;
    case (req_type_t'(req.req_type))
      REQ_TICK: begin
        if (check_due) begin
          st_nxt.last_check_ms = req.now_ms;
          st_nxt.latched_temp  = req.temperature;
          if (req.temperature >= cfg.temp_critical) begin
            if (!st.throttle_flag || st.cur_freq > FREQ_LOW) begin
              st_nxt.throttle_flag = 1'b1;
              st_nxt.cur_freq      = FREQ_LOW;
              changed              = 1'b1;
            end
          end else if (req.temperature >= cfg.temp_throttle) begin
            if (!st.throttle_flag || st.cur_freq > FREQ_MID) begin
              st_nxt.throttle_flag = 1'b1;
              st_nxt.cur_freq      = FREQ_MID;
              changed              = 1'b1;
            end
          end else if (st.throttle_flag && req.temperature <= cfg.temp_recovery) begin
            st_nxt.throttle_flag = 1'b0;
            st_nxt.cur_freq      = st.target_freq;
            changed              = 1'b1;
          end
          // auto profile follows the load flags while unthrottled
          if (st.profile_mode == PROF_AUTO && !st_nxt.throttle_flag &&
              want_freq != st.target_freq) begin
            st_nxt.target_freq = want_freq;
            st_nxt.cur_freq    = want_freq;
            changed            = 1'b1;
          end
        end
        if (cfg.sleep_timeout_ms != '0 && !st.display_sleep_flag &&
            !req.is_recording && !req.is_streaming && idle_due) begin
          st_nxt.display_sleep_flag = 1'b1;
          cmd                       = CMD_SLEEP_IN;
          if (!st_nxt.throttle_flag) begin
            st_nxt.cur_freq = FREQ_LOW;
            changed         = 1'b1;
          end
        end
      end
      REQ_ACTIVITY: begin
        st_nxt.last_activity_ms = req.now_ms;
        if (st.display_sleep_flag) begin
          st_nxt.display_sleep_flag = 1'b0;
          cmd                       = CMD_SLEEP_OUT;
        end
      end
      REQ_PROFILE: begin
        st_nxt.profile_mode  = req.new_profile;
        st_nxt.throttle_flag = 1'b0;
        st_nxt.target_freq   = profile_target(req.new_profile);
        st_nxt.cur_freq      = profile_target(req.new_profile);
        changed              = 1'b1;
      end
      default: ;  // unused request: report state unchanged
    endcase
  end

  assign rsp.freq_mhz       = st_nxt.cur_freq;
  assign rsp.target_mhz     = st_nxt.target_freq;
  assign rsp.throttled      = st_nxt.throttle_flag;
  assign rsp.display_asleep = st_nxt.display_sleep_flag;
  assign rsp.display_cmd    = cmd;
  assign rsp.freq_changed   = changed;
  assign rsp.temp_latched   = st_nxt.latched_temp;

endmodule

### sv/thermal_dvfs_governor.sv
// ----------------------------------------------------------------------------
// thermal_dvfs_governor: thermal and activity clock-frequency governor
//
//   Channel | Ports                          | Direction | Payload
//   --------+--------------------------------+-----------+------------------
//   in      | in_valid, in_ready, in_data    | to block  | in_req_t
//   out     | out_valid, out_ready, out_data | from block| out_rsp_t
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | to block | index, data
//
// One request per cycle sustained while out_ready stays high. An accepted
// request is held in the input register, evaluated against the governor
// state and its result registered in the result register; state updates
// with that result, so the next request sees it. Synchronous active-low reset
// clears state and both stage valids. An output stall holds the result and,
// once the input register is also full, drops in_ready. cfg_ready is always high.
// ----------------------------------------------------------------------------
module thermal_dvfs_governor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tdg_pkg::in_req_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tdg_pkg::out_rsp_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tdg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tdg_pkg::CfgDataW-1:0]  cfg_data
);
  import tdg_pkg::*;

  tdg_cfg_t   cfg;
  in_req_t    req_r;
  logic       req_vld_r;
  out_rsp_t   rsp_r;
  out_rsp_t   rsp_nxt;
  logic       rsp_vld_r;
  gov_state_t st_r;
  gov_state_t st_nxt;
  logic       advance;

  assign cfg_ready = 1'b1;

  tdg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  tdg_step u_step (
    .req    (req_r),
    .st     (st_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .rsp    (rsp_nxt)
  );

  // move the held request into the result register when it has room
  assign advance  = req_vld_r && (!rsp_vld_r || out_ready);
  assign in_ready = !req_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_ready) begin
      req_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_vld_r <= 1'b0;
    end else if (advance) begin
      rsp_vld_r <= 1'b1;
    end else if (out_ready) begin
      rsp_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_r <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.cur_freq           <= FREQ_HIGH;
      st_r.target_freq        <= FREQ_HIGH;
      st_r.profile_mode       <= PROF_AUTO;
      st_r.throttle_flag      <= 1'b0;
      st_r.display_sleep_flag <= 1'b0;
      st_r.last_check_ms      <= '0;
      st_r.last_activity_ms   <= '0;
      st_r.latched_temp       <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid = rsp_vld_r;
  assign out_data  = rsp_r;

  a_throttle_not_high: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.throttle_flag |-> (st_r.cur_freq != FREQ_HIGH))
    else $error("throttled at full frequency");

  a_sleep_in_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.display_cmd == CMD_SLEEP_IN) |-> out_data.display_asleep)
    else $error("sleep-in command without display asleep");

  a_sleep_out_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.display_cmd == CMD_SLEEP_OUT) |-> !out_data.display_asleep)
    else $error("sleep-out command with display still asleep");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (req_vld_r && rsp_vld_r && !out_ready))
    else $error("input stalled while a stage has room");

endmodule

### tb/sv/tb_thermal_dvfs_governor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thermal_dvfs_governor: self-checking bench for the thermal clock governor
// Sends ticks, activity events and profile changes through the request
// channel with bursty gaps and a stalling receiver. A local copy of the
// governor state recomputes every response, and the responses are compared
// field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_thermal_dvfs_governor;
  import tdg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned LONG_HOLD   = 400;
  localparam logic [CfgIdxW-1:0] REG_UNMAPPED = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_req_t             in_data;
  logic                out_valid;
  logic                out_ready;
  out_rsp_t            out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // governor state and settings as the block should hold them
  gov_state_t  gov_st;
  tdg_cfg_t    gov_cfg;
  out_rsp_t    gov_rsp_q[$];

  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic [TsW-1:0] clock_ms;
  int unsigned step_max;
  bit          gaps_on;
  int unsigned burst_left;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned rx_phase_left;
  int unsigned rx_mode;

  thermal_dvfs_governor u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_thermal_dvfs_governor: FAIL");
      $finish;
    end
  end

  // Advance the governor by one request and return the response it owes.
  function automatic out_rsp_t govern(input in_req_t r);
    out_rsp_t                rsp;
    logic [TsW-1:0]          since;
    logic signed [TempW-1:0] t;
    logic [FreqW-1:0]        want;
    logic                    changed;
    logic [1:0]              cmd;
    changed = 1'b0;
    cmd     = CMD_NONE;
    t       = r.temperature;
    case (r.req_type)
      REQ_TICK: begin
        since = r.now_ms - gov_st.last_check_ms;
        if (since >= gov_cfg.thermal_period_ms) begin
          gov_st.last_check_ms = r.now_ms;
          gov_st.latched_temp  = t;
          if (t >= $signed(gov_cfg.temp_critical)) begin
            if (!gov_st.throttle_flag || gov_st.cur_freq > FREQ_LOW) begin
              gov_st.throttle_flag = 1'b1;
              gov_st.cur_freq      = FREQ_LOW;
              changed              = 1'b1;
            end
          end else if (t >= $signed(gov_cfg.temp_throttle)) begin
            if (!gov_st.throttle_flag || gov_st.cur_freq > FREQ_MID) begin
              gov_st.throttle_flag = 1'b1;
              gov_st.cur_freq      = FREQ_MID;
              changed              = 1'b1;
            end
          end else if (gov_st.throttle_flag && t <= $signed(gov_cfg.temp_recovery)) begin
            gov_st.throttle_flag = 1'b0;
            gov_st.cur_freq      = gov_st.target_freq;
            changed              = 1'b1;
          end
          if (gov_st.profile_mode == PROF_AUTO && !gov_st.throttle_flag) begin
            want = (r.is_recording || r.is_streaming || r.is_high_load) ? FREQ_HIGH : FREQ_MID;
            if (want != gov_st.target_freq) begin
              gov_st.target_freq = want;
              gov_st.cur_freq    = want;
              changed            = 1'b1;
            end
          end
        end
        since = r.now_ms - gov_st.last_activity_ms;
        if (gov_cfg.sleep_timeout_ms != 0 && !gov_st.display_sleep_flag &&
            !r.is_recording && !r.is_streaming && since >= gov_cfg.sleep_timeout_ms) begin
          gov_st.display_sleep_flag = 1'b1;
          cmd = CMD_SLEEP_IN;
          if (!gov_st.throttle_flag) begin
            gov_st.cur_freq = FREQ_LOW;
            changed         = 1'b1;
          end
        end
      end
      REQ_ACTIVITY: begin
        gov_st.last_activity_ms = r.now_ms;
        if (gov_st.display_sleep_flag) begin
          gov_st.display_sleep_flag = 1'b0;
          cmd = CMD_SLEEP_OUT;
        end
      end
      REQ_PROFILE: begin
        gov_st.profile_mode  = r.new_profile;
        gov_st.throttle_flag = 1'b0;
        case (r.new_profile)
          PROF_PERF:     gov_st.target_freq = FREQ_HIGH;
          PROF_BALANCED: gov_st.target_freq = FREQ_MID;
          PROF_ECO:      gov_st.target_freq = FREQ_LOW;
          default:       gov_st.target_freq = FREQ_HIGH;
        endcase
        gov_st.cur_freq = gov_st.target_freq;
        changed         = 1'b1;
      end
      default: ;
    endcase
    rsp.freq_mhz       = gov_st.cur_freq;
    rsp.target_mhz     = gov_st.target_freq;
    rsp.throttled      = gov_st.throttle_flag;
    rsp.display_asleep = gov_st.display_sleep_flag;
    rsp.display_cmd    = cmd;
    rsp.freq_changed   = changed;
    rsp.temp_latched   = gov_st.latched_temp;
    return rsp;
  endfunction

  // Track register writes and requests at the edge they are taken, then check
  // whatever response leaves the block at that edge.
  always @(posedge clk) begin : track
    out_rsp_t due;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SLEEP_TIMEOUT: gov_cfg.sleep_timeout_ms  = cfg_data;
          REG_THERMAL_PER:   gov_cfg.thermal_period_ms = cfg_data[PerW-1:0];
          REG_TEMP_CRIT:     gov_cfg.temp_critical     = cfg_data[TempW-1:0];
          REG_TEMP_THROT:    gov_cfg.temp_throttle     = cfg_data[TempW-1:0];
          REG_TEMP_RECOV:    gov_cfg.temp_recovery     = cfg_data[TempW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        gov_rsp_q.push_back(govern(in_data));
      if (out_valid && out_ready) begin
        if (gov_rsp_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("[%0t] response with no request outstanding: freq %0d tgt %0d",
                     $time, out_data.freq_mhz, out_data.target_mhz);
        end else begin
          due = gov_rsp_q.pop_front();
          if (out_data.freq_mhz       !== due.freq_mhz       ||
              out_data.target_mhz     !== due.target_mhz     ||
              out_data.throttled      !== due.throttled      ||
              out_data.display_asleep !== due.display_asleep ||
              out_data.display_cmd    !== due.display_cmd    ||
              out_data.freq_changed   !== due.freq_changed   ||
              out_data.temp_latched   !== due.temp_latched) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS) begin
              $display("[%0t] mismatch  freq tgt thr slp cmd chg temp", $time);
              $display("  wanted  %0d %0d %0b %0b %0d %0b %0d", due.freq_mhz,
                       due.target_mhz, due.throttled, due.display_asleep,
                       due.display_cmd, due.freq_changed, $signed(due.temp_latched));
              $display("  got     %0d %0d %0b %0b %0d %0b %0d", out_data.freq_mhz,
                       out_data.target_mhz, out_data.throttled, out_data.display_asleep,
                       out_data.display_cmd, out_data.freq_changed,
                       $signed(out_data.temp_latched));
            end
          end
        end
      end
    end
  end

  // Receiver: changes its stall pattern every so often; a long hold-off is
  // counted out here once requested.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode       = $urandom_range(0, 3);
        rx_phase_left = $urandom_range(16, 160);
      end else begin
        rx_phase_left--;
      end
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= ((rx_phase_left % 6) < 2);
      endcase
    end
  end

  // When gaps are on, insert a random gap at the end of each burst.
  task automatic pace();
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_req(input in_req_t r);
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pace();
  endtask

  // Hold off new requests until every response owed has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (gov_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [TsW-1:0] tmo, input logic [PerW-1:0] per,
                           input logic signed [TempW-1:0] crit,
                           input logic signed [TempW-1:0] thr,
                           input logic signed [TempW-1:0] rec, input bit poke);
    logic [CfgDataW-1:0] val;
    settle();
    write_reg(REG_SLEEP_TIMEOUT, tmo);
    // unused upper bits carry noise
    val = $urandom;
    val[PerW-1:0] = per;
    write_reg(REG_THERMAL_PER, val);
    write_reg(REG_TEMP_CRIT, {{(CfgDataW-TempW){crit[TempW-1]}}, crit});
    write_reg(REG_TEMP_THROT, {{(CfgDataW-TempW){thr[TempW-1]}}, thr});
    write_reg(REG_TEMP_RECOV, {{(CfgDataW-TempW){rec[TempW-1]}}, rec});
    if (poke)
      write_reg(REG_UNMAPPED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_req_t mk(input logic [1:0] req, input logic [TsW-1:0] now,
                                 input logic signed [TempW-1:0] temp, input logic rec,
                                 input logic strm, input logic load, input logic [1:0] prof);
    in_req_t r;
    r.req_type     = req;
    r.now_ms       = now;
    r.temperature  = temp;
    r.is_recording = rec;
    r.is_streaming = strm;
    r.is_high_load = load;
    r.new_profile  = prof;
    return r;
  endfunction

  // Temperatures cluster round the thresholds in force, with fixed samples
  // at 2047 and -1024, and the odd fully random sample.
  function automatic logic signed [TempW-1:0] pick_temp();
    logic signed [TempW-1:0] t;
    int offs;
    offs = int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 6))
      0:       t = TempW'(gov_cfg.temp_critical + offs);
      1:       t = TempW'(gov_cfg.temp_throttle + offs);
      2:       t = TempW'(gov_cfg.temp_recovery + offs);
      3, 4:    t = TempW'($urandom);
      5:       t = -12'sd1024;
      default: t = 12'sd2047;
    endcase
    return t;
  endfunction

  task automatic gen_req(output in_req_t r);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    r.new_profile  = 2'($urandom_range(0, 3));
    r.is_recording = ($urandom_range(0, 3) == 0);
    r.is_streaming = ($urandom_range(0, 3) == 0);
    r.is_high_load = 1'($urandom_range(0, 1));
    r.temperature  = pick_temp();
    if (roll < 75)      r.req_type = REQ_TICK;
    else if (roll < 89) r.req_type = REQ_ACTIVITY;
    else if (roll < 96) r.req_type = REQ_PROFILE;
    else                r.req_type = REQ_UNUSED;
    // an occasional stray timestamp, otherwise time moves forward
    if ($urandom_range(0, 49) == 0) begin
      r.now_ms = $urandom;
    end else begin
      clock_ms = clock_ms + $urandom_range(0, step_max);
      r.now_ms = clock_ms;
    end
  endtask

  task automatic run_traffic(input int unsigned count);
    in_req_t r;
    repeat (count) begin
      gen_req(r);
      send_req(r);
    end
  endtask

  task automatic test_reset_defaults();
    send_req(mk(REQ_TICK, 32'd0, 12'sd0, 1'b0, 1'b0, 1'b0, PROF_ECO));
    send_req(mk(REQ_TICK, 32'd999, 12'sd2047, 1'b1, 1'b1, 1'b1, PROF_AUTO));
    send_req(mk(REQ_TICK, 32'd1000, 12'sd1312, 1'b0, 1'b0, 1'b0, PROF_AUTO));
    send_req(mk(REQ_TICK, 32'd2000, 12'sd1311, 1'b0, 1'b0, 1'b0, PROF_AUTO));
    send_req(mk(REQ_TICK, 32'd3000, 12'sd1089, 1'b0, 1'b0, 1'b0, PROF_AUTO));
    send_req(mk(REQ_TICK, 32'd4000, 12'sd1088, 1'b0, 1'b0, 1'b0, PROF_AUTO));
    send_req(mk(REQ_TICK, 32'd5000, 12'sd1200, 1'b0, 1'b0, 1'b1, PROF_AUTO));
    send_req(mk(REQ_TICK, 32'd6000, -12'sd1024, 1'b1, 1'b0, 1'b0, PROF_AUTO));
    send_req(mk(REQ_TICK, 32'hFFFF_FFFF, 12'sd2047, 1'b0, 1'b1, 1'b0, PROF_AUTO));
    // elapsed time wraps through zero
    send_req(mk(REQ_TICK, 32'd999, 12'sd0, 1'b0, 1'b0, 1'b0, PROF_AUTO));
    send_req(mk(REQ_ACTIVITY, 32'hFFFF_FFFF, -12'sd1024, 1'b1, 1'b1, 1'b1, PROF_PERF));
    send_req(mk(REQ_PROFILE, 32'hAAAA_5555, 12'sd2047, 1'b1, 1'b1, 1'b1, PROF_PERF));
    send_req(mk(REQ_PROFILE, 32'h5555_AAAA, 12'sd0, 1'b0, 1'b0, 1'b0, PROF_BALANCED));
    send_req(mk(REQ_PROFILE, 32'd0, -12'sd1, 1'b0, 1'b0, 1'b0, PROF_ECO));
    send_req(mk(REQ_PROFILE, 32'd0, 12'sd0, 1'b0, 1'b0, 1'b0, PROF_AUTO));
    send_req(mk(REQ_UNUSED, 32'hFFFF_FFFF, -12'sd1, 1'b1, 1'b1, 1'b1, PROF_ECO));
  endtask

  task automatic test_display_sleep();
    configure(32'd10, 16'd1, RST_TEMP_CRIT, RST_TEMP_THROT, RST_TEMP_RECOV, 1'b0);
    send_req(mk(REQ_ACTIVITY, 32'd100, 12'sd0, 1'b0, 1'b0, 1'b0, PROF_AUTO));
    send_req(mk(REQ_TICK, 32'd105, 12'sd1400, 1'b0, 1'b0, 1'b0, PROF_AUTO));
    // sleep while throttled keeps the clock
    send_req(mk(REQ_TICK, 32'd110, 12'sd1400, 1'b0, 1'b0, 1'b0, PROF_AUTO));
    send_req(mk(REQ_ACTIVITY, 32'd111, 12'sd0, 1'b0, 1'b0, 1'b0, PROF_AUTO));
    send_req(mk(REQ_TICK, 32'd125, 12'sd0, 1'b1, 1'b0, 1'b0, PROF_AUTO));
    send_req(mk(REQ_TICK, 32'd125, 12'sd0, 1'b0, 1'b1, 1'b0, PROF_AUTO));
    send_req(mk(REQ_TICK, 32'd126, 12'sd0, 1'b0, 1'b0, 1'b0, PROF_AUTO));
    send_req(mk(REQ_TICK, 32'd127, 12'sd0, 1'b0, 1'b0, 1'b0, PROF_AUTO));
  endtask

  task automatic test_zero_period();
    configure(32'd0, 16'd0, RST_TEMP_CRIT, RST_TEMP_THROT, RST_TEMP_RECOV, 1'b0);
    send_req(mk(REQ_TICK, 32'd500, 12'sd1250, 1'b0, 1'b0, 1'b1, PROF_AUTO));
    send_req(mk(REQ_TICK, 32'd500, 12'sd1300, 1'b0, 1'b0, 1'b1, PROF_AUTO));
    send_req(mk(REQ_TICK, 32'd500, 12'sd1000, 1'b0, 1'b0, 1'b0, PROF_AUTO));
  endtask

  task automatic test_default_thresholds();
    configure(32'd40, 16'd16, RST_TEMP_CRIT, RST_TEMP_THROT, RST_TEMP_RECOV, 1'b0);
    step_max = 8;
    run_traffic(400);
  endtask

  task automatic test_extreme_settings();
    configure(32'hFFFF_FFFF, 16'hFFFF, 12'sd2047, 12'sd2047, -12'sd1024, 1'b1);
    step_max = 30000;
    gaps_on  = 1'b0;
    run_traffic(150);
    configure(32'd1, 16'd0, -12'sd1024, -12'sd1024, -12'sd1024, 1'b0);
    step_max = 3;
    gaps_on  = 1'b1;
    run_traffic(150);
  endtask

  task automatic test_random_settings();
    logic [TsW-1:0]          tmo;
    logic signed [TempW-1:0] crit, thr, rec;
    int                      base;
    repeat (4) begin
      case ($urandom_range(0, 3))
        0:       tmo = 32'd0;
        1:       tmo = $urandom;
        default: tmo = $urandom_range(1, 120);
      endcase
      if ($urandom_range(0, 1) == 0) begin
        crit = TempW'($urandom);
        thr  = TempW'($urandom);
        rec  = TempW'($urandom);
      end else begin
        base = $urandom_range(0, 1500);
        crit = TempW'(base + 100);
        thr  = TempW'(base + 50);
        rec  = TempW'(base);
      end
      configure(tmo, PerW'($urandom_range(0, 40)), crit, thr, rec, 1'b0);
      step_max = $urandom_range(1, 12);
      run_traffic(100);
    end
  endtask

  task automatic test_timestamp_wrap();
    configure(32'd25, 16'd8, RST_TEMP_CRIT, RST_TEMP_THROT, RST_TEMP_RECOV, 1'b0);
    clock_ms = 32'hFFFF_FF00;
    step_max = 6;
    run_traffic(250);
  endtask

  task automatic test_backpressure();
    configure(32'd30, 16'd4, RST_TEMP_CRIT, RST_TEMP_THROT, RST_TEMP_RECOV, 1'b0);
    step_max = 5;
    // receiver holds off while requests keep coming, so the block backs up
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    run_traffic(100);
    settle();
    gaps_on = 1'b1;
    repeat (4) begin
      run_traffic(50);
      settle();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    hold_req      = 1'b0;
    hold_left     = 0;
    rx_phase_left = 0;
    rx_mode       = 0;
    gaps_on       = 1'b1;
    burst_left    = 0;
    step_max      = 8;
    clock_ms      = '0;
    gov_st              = '0;
    gov_st.cur_freq     = FREQ_HIGH;
    gov_st.target_freq  = FREQ_HIGH;
    gov_st.profile_mode = PROF_AUTO;
    gov_cfg.sleep_timeout_ms  = RST_SLEEP_TIMEOUT;
    gov_cfg.thermal_period_ms = RST_THERMAL_PER;
    gov_cfg.temp_critical     = RST_TEMP_CRIT;
    gov_cfg.temp_throttle     = RST_TEMP_THROT;
    gov_cfg.temp_recovery     = RST_TEMP_RECOV;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_display_sleep();
    test_zero_period();
    test_default_thresholds();
    test_extreme_settings();
    test_random_settings();
    test_timestamp_wrap();
    test_backpressure();

    settle();
    repeat (10) @(posedge clk);
    if (fail_cnt == 0 && gov_rsp_q.size() == 0)
      $display("tb_thermal_dvfs_governor: PASS");
    else
      $display("tb_thermal_dvfs_governor: FAIL");
    $finish;
  end

endmodule

### files.f
sv/tdg_pkg.sv
sv/tdg_cfg_regs.sv
sv/tdg_step.sv
sv/thermal_dvfs_governor.sv
tb/sv/tb_thermal_dvfs_governor.sv
